/* rtl/assert_macros.svh */
// assertion macros shared by the rgb to ycbcr block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// general form: explicit clock and reset
`define RGBYCC_ASSERT(label, ck, rs, prop, msg) \
  label: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// common form: uses clk and rst of the enclosing module
`define RGBYCC_CHECK(label, prop, msg) \
  `RGBYCC_ASSERT(label, clk, rst, prop, msg)

`endif

/* rtl/rgbycc_pkg.sv */
// package: constants, types and helpers of the rgb to ycbcr block
package rgbycc_pkg;

  localparam int BPR_W              = 7;
  localparam int MAX_BLOCKS_DEFAULT = 64;
  localparam int SUM_W              = 12;
  localparam int OUT_COL_W          = 6;
  localparam int PROD_W             = 24;
  localparam int ACC_W              = 25;

  localparam logic [BPR_W-1:0] BPR_RESET = 7'd64;

  // unsigned q16 coefficients
  localparam logic [15:0] Y_R  = 16'd19595;
  localparam logic [15:0] Y_G  = 16'd38470;
  localparam logic [15:0] Y_B  = 16'd7471;
  localparam logic [15:0] CB_R = 16'd11056;
  localparam logic [15:0] CB_G = 16'd21712;
  localparam logic [15:0] CR_G = 16'd27440;
  localparam logic [15:0] CR_B = 16'd5328;

  localparam logic [ACC_W-1:0] ROUND_HALF = 25'd32768;
  // 128 offset plus rounding half, in q16
  localparam logic [ACC_W-1:0] CHROMA_OFS = 25'd8421376;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic first;
  } accum_ctl_t;

  function automatic logic [7:0] sat8(input logic [8:0] q);
    return (q > 9'd255) ? 8'd255 : q[7:0];
  endfunction

  // rounded mean of sixteen samples
  function automatic logic [7:0] avg16(input logic [SUM_W-1:0] sum);
    logic [SUM_W:0] t;
    t = {1'b0, sum} + (SUM_W+1)'(8);
    return sat8(t[SUM_W:4]);
  endfunction

endpackage

/* rtl/rgbycc_if.sv */
// stream interfaces for pixel words in and result words out
interface rgbycc_in_if;
  logic       valid;
  logic       ready;
  logic       frame_start;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, frame_start, red, green, blue, input ready);
  modport sink   (input valid, frame_start, red, green, blue, output ready);
endinterface

interface rgbycc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma;
  logic       chroma_valid;
  logic [7:0] cb_average;
  logic [7:0] cr_average;
  logic [5:0] block_column;

  modport source (output valid, luma, chroma_valid, cb_average, cr_average, block_column,
                  input ready);
  modport sink   (input valid, luma, chroma_valid, cb_average, cr_average, block_column,
                  output ready);
endinterface

/* rtl/rgbycc_color.sv */
// two-stage color converter: constant products, then rounded clamped y, cb, cr
module rgbycc_color import rgbycc_pkg::*; (
  input  logic       clk,
  input  logic       en1,
  input  logic       en2,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  output logic [7:0] luma,
  output logic [7:0] cb,
  output logic [7:0] cr
);

  logic [PROD_W-1:0] p_yr, p_yg, p_yb, p_cbr, p_cbg, p_crg, p_crb;
  logic [7:0]        r1, b1;
  logic [ACC_W-1:0]  y_acc, cb_acc, cr_acc;

  always_ff @(posedge clk) begin
    if (en1) begin
      p_yr  <= PROD_W'(red)   * Y_R;
      p_yg  <= PROD_W'(green) * Y_G;
      p_yb  <= PROD_W'(blue)  * Y_B;
      p_cbr <= PROD_W'(red)   * CB_R;
      p_cbg <= PROD_W'(green) * CB_G;
      p_crg <= PROD_W'(green) * CR_G;
      p_crb <= PROD_W'(blue)  * CR_B;
      r1    <= red;
      b1    <= blue;
    end
  end

  // dividends never go negative, so plain unsigned math is exact
  always_comb begin
    y_acc  = ACC_W'(p_yr) + ACC_W'(p_yg) + ACC_W'(p_yb) + ROUND_HALF;
    cb_acc = CHROMA_OFS + {2'b00, b1, 15'd0} - ACC_W'(p_cbr) - ACC_W'(p_cbg);
    cr_acc = CHROMA_OFS + {2'b00, r1, 15'd0} - ACC_W'(p_crg) - ACC_W'(p_crb);
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      luma <= sat8(y_acc[24:16]);
      cb   <= sat8(cb_acc[24:16]);
      cr   <= sat8(cr_acc[24:16]);
    end
  end

endmodule

/* rtl/rgbycc_accum.sv */
// block-column sum memory with read-modify-write and write-to-read forwarding
module rgbycc_accum import rgbycc_pkg::*; #(
  parameter int MAX_BLOCKS_PER_ROW = MAX_BLOCKS_DEFAULT,
  parameter int BLK_W              = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  accum_ctl_t       ctl,
  input  logic [BLK_W-1:0] rd_blk,
  input  logic [BLK_W-1:0] wr_blk,
  input  logic [7:0]       cb,
  input  logic [7:0]       cr,
  output logic [7:0]       cb_avg,
  output logic [7:0]       cr_avg
);

  logic [2*SUM_W-1:0] mem [MAX_BLOCKS_PER_ROW];
  logic [2*SUM_W-1:0] rd_data;
  logic [2*SUM_W-1:0] fwd_data;
  logic               fwd;
  logic [SUM_W-1:0]   cb_old, cr_old, cb_new, cr_new;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_blk] <= {cb_new, cr_new};
    end
    if (ctl.rd_en) begin
      rd_data  <= mem[rd_blk];
      fwd_data <= {cb_new, cr_new};
    end
  end

  // the read misses a write to the same entry at that edge
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else if (ctl.rd_en) begin
      fwd <= ctl.wr_en && (wr_blk == rd_blk);
    end
  end

  always_comb begin
    {cb_old, cr_old} = fwd ? fwd_data : rd_data;
    cb_new = ctl.first ? SUM_W'(cb) : cb_old + SUM_W'(cb);
    cr_new = ctl.first ? SUM_W'(cr) : cr_old + SUM_W'(cr);
    cb_avg = avg16(cb_new);
    cr_avg = avg16(cr_new);
  end

endmodule

/* rtl/rgb_to_ycbcr_chroma_box_average.sv */
// top level: rgb to ycbcr with 4x4 chroma box averaging
//
// pixels (sink) takes one rgb word per clock in raster order; frame_start
// on a word restarts column and row counting at that pixel. results
// (source) gives one word per pixel: luma always, and on the pixel that
// closes a 4x4 block chroma_valid with the rounded cb/cr means and the
// block's column index (zeros otherwise).
// cfg_write/cfg_data set blocks_per_row (image width / 4); the user
// writes them only while idle; the block does not enforce it. stages:
// product, convert and memory read, accumulate into the output register.
// throughput: 1 word per clock; the per-column sum memory is read one
// stage ahead and written back when s2 advances; consecutive pixels of
// a block are covered by forwarding the value just written.
// reset (rst, synchronous): counters cleared, width back to 64 blocks,
// pipeline emptied; the sum memory needs no clearing since a block's
// first pixel overwrites its entry.
// when results is stalled the word waits in the output register and the
// two inner stages keep filling, then pixels.ready drops.
`include "assert_macros.svh"

module rgb_to_ycbcr_chroma_box_average import rgbycc_pkg::*; #(
  parameter int MAX_BLOCKS_PER_ROW = MAX_BLOCKS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [BPR_W-1:0] cfg_data,
  rgbycc_in_if.sink        pixels,
  rgbycc_out_if.source     results
);

  localparam int COL_W = $clog2(4 * MAX_BLOCKS_PER_ROW);
  localparam int BLK_W = (MAX_BLOCKS_PER_ROW > 1) ? $clog2(MAX_BLOCKS_PER_ROW) : 1;
  localparam int CMP_W = (COL_W + 1 > BPR_W + 2) ? COL_W + 1 : BPR_W + 2;

  logic [BPR_W-1:0] blocks_per_row;
  logic [COL_W-1:0] pixel_column, pixel_column_next;
  logic [1:0]       row_phase, row_phase_next;

  logic [COL_W-1:0] col_cur;
  logic [1:0]       phase_cur;
  logic [BLK_W-1:0] blk_cur;
  logic             first_cur, last_cur;
  logic [CMP_W-1:0] eff_blocks, width_px, col_inc;
  logic             wrap;

  logic             accept, s1_adv, s2_adv;
  logic             s1_valid, s1_first, s1_last;
  logic             s2_valid, s2_first, s2_last;
  logic [BLK_W-1:0] s1_blk, s2_blk;

  logic [7:0]       luma2, cb2, cr2, cb_avg, cr_avg;
  accum_ctl_t       actl;

  // handshakes
  assign s2_adv       = s2_valid && (!results.valid || results.ready);
  assign s1_adv       = s1_valid && (!s2_valid || s2_adv);
  assign pixels.ready = !s1_valid || s1_adv;
  assign accept       = pixels.valid && pixels.ready;

  // position of the incoming pixel
  always_comb begin
    col_cur   = pixels.frame_start ? '0 : pixel_column;
    phase_cur = pixels.frame_start ? 2'd0 : row_phase;
    blk_cur   = BLK_W'(col_cur >> 2);
    first_cur = (phase_cur == 2'd0) && (col_cur[1:0] == 2'd0);
    last_cur  = (phase_cur == 2'd3) && (col_cur[1:0] == 2'd3);

    if (blocks_per_row == '0) begin
      eff_blocks = CMP_W'(1);
    end else if (CMP_W'(blocks_per_row) > CMP_W'(MAX_BLOCKS_PER_ROW)) begin
      eff_blocks = CMP_W'(MAX_BLOCKS_PER_ROW);
    end else begin
      eff_blocks = CMP_W'(blocks_per_row);
    end
    width_px = eff_blocks << 2;
    col_inc  = CMP_W'(col_cur) + CMP_W'(1);
    wrap     = col_inc >= width_px;

    pixel_column_next = wrap ? '0 : COL_W'(col_inc);
    row_phase_next    = wrap ? phase_cur + 2'd1 : phase_cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blocks_per_row <= BPR_RESET;
    end else if (cfg_write) begin
      blocks_per_row <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_column <= '0;
      row_phase    <= 2'd0;
    end else if (accept) begin
      pixel_column <= pixel_column_next;
      row_phase    <= row_phase_next;
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      results.valid <= 1'b0;
    end else begin
      if (pixels.ready) begin
        s1_valid <= pixels.valid;
      end
      if (!s2_valid || s2_adv) begin
        s2_valid <= s1_valid;
      end
      if (!results.valid || results.ready) begin
        results.valid <= s2_valid;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_blk   <= blk_cur;
      s1_first <= first_cur;
      s1_last  <= last_cur;
    end
    if (s1_adv) begin
      s2_blk   <= s1_blk;
      s2_first <= s1_first;
      s2_last  <= s1_last;
    end
    if (s2_adv) begin
      results.luma         <= luma2;
      results.chroma_valid <= s2_last;
      results.cb_average   <= s2_last ? cb_avg : 8'd0;
      results.cr_average   <= s2_last ? cr_avg : 8'd0;
      results.block_column <= s2_last ? OUT_COL_W'(s2_blk) : '0;
    end
  end

  rgbycc_color u_color (
    .clk   (clk),
    .en1   (accept),
    .en2   (s1_adv),
    .red   (pixels.red),
    .green (pixels.green),
    .blue  (pixels.blue),
    .luma  (luma2),
    .cb    (cb2),
    .cr    (cr2)
  );

  assign actl.rd_en = s1_adv;
  assign actl.wr_en = s2_adv;
  assign actl.first = s2_first;

  rgbycc_accum #(
    .MAX_BLOCKS_PER_ROW (MAX_BLOCKS_PER_ROW),
    .BLK_W              (BLK_W)
  ) u_accum (
    .clk    (clk),
    .rst    (rst),
    .ctl    (actl),
    .rd_blk (s1_blk),
    .wr_blk (s2_blk),
    .cb     (cb2),
    .cr     (cr2),
    .cb_avg (cb_avg),
    .cr_avg (cr_avg)
  );

  `RGBYCC_CHECK(chk_chroma_cleared, results.valid && !results.chroma_valid |-> results.cb_average == 8'd0 && results.cr_average == 8'd0 && results.block_column == '0, "chroma fields set on a word that closes no block")
  `RGBYCC_CHECK(chk_s2_hold, s2_valid && !s2_adv |=> s2_valid && $stable(s2_blk), "stalled accumulate stage lost its word")
  `RGBYCC_CHECK(chk_frame_restart, accept && pixels.frame_start |=> (pixel_column == COL_W'(1) && row_phase == 2'd0) || (pixel_column == '0 && row_phase == 2'd1), "frame start did not restart counting")

endmodule
